// File: sv/assert_macros.svh
// assertion helpers used by framebuffer_pixel_unpacker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fbpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpu_pkg
// Types, register indexes and helpers of the framebuffer pixel unpacker.
// ----------------------------------------------------------------------------
package fbpu_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_DEPTH = 2'd0;
	localparam logic [1:0] REG_SCALE = 2'd1;
	localparam logic [1:0] REG_LINE  = 2'd2;

	localparam logic [2:0]  DEPTH_16BPP  = 3'd4;
	localparam logic [2:0]  DEPTH_32BPP  = 3'd5;
	localparam logic [1:0]  SCALE_RESET  = 2'd1;
	localparam logic [11:0] LINE_RESET   = 12'd640;

	typedef enum logic [1:0] {
		KIND_PAL,
		KIND_565,
		KIND_WORD
	} pix_kind_t;

	// pixels held in one 32-bit word
	function automatic logic [5:0] pix_count(input logic [2:0] depth);
		logic [5:0] n;
		case (depth)
			3'd0:    n = 6'd32;
			3'd1:    n = 6'd16;
			3'd2:    n = 6'd8;
			3'd3:    n = 6'd4;
			3'd4:    n = 6'd2;
			default: n = 6'd1;
		endcase
		return n;
	endfunction

	// mask for a palette index at the indexed depths
	function automatic logic [7:0] idx_mask(input logic [2:0] depth);
		logic [7:0] m;
		case (depth)
			3'd0:    m = 8'h01;
			3'd1:    m = 8'h03;
			3'd2:    m = 8'h0f;
			default: m = 8'hff;
		endcase
		return m;
	endfunction

	// move the next pixel down to bit 0
	function automatic logic [31:0] next_digit(input logic [31:0] w, input logic [2:0] depth);
		logic [31:0] r;
		case (depth)
			3'd0:    r = {1'b0, w[31:1]};
			3'd1:    r = {2'b0, w[31:2]};
			3'd2:    r = {4'b0, w[31:4]};
			3'd3:    r = {8'b0, w[31:8]};
			3'd4:    r = {16'b0, w[31:16]};
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/framebuffer_pixel_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_unpacker
// Unpacks framebuffer words into RGB pixels, through a colour palette at the indexed depths.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one beat per framebuffer word
//   (func 0) or palette write (func 1). output channel (out_valid/out_ready)
//   gives one beat per output pixel with word_done and line_end flags.
//   registers depth_code, horizontal_scale, line_pixels sit on the apb port
//   at 0x0, 0x4, 0x8; write them only while the block is idle.
// timing:
//   a palette write goes straight into the palette ram. a word is shifted out
//   one pixel digit per cycle through a shift register while the output stage
//   can take it; the palette ram read data is registered at the same edge as
//   the output stage, so within a word the pixels leave one beat per cycle
//   while out_ready is high: up to 32 source pixels per word, each sent twice
//   when bit 1 of the horizontal scale is set. the next word is taken the
//   cycle after its last pixel has moved to the output register.
// reset:
//   registers return to 1bpp, scale 1, 640 pixels; the line position is
//   zero and every palette entry reads as zero until written.
// stall:
//   a low out_ready holds the output beat and the word shift register;
//   in_ready stays low until the word has drained into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framebuffer_pixel_unpacker
	import fbpu_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256,
	parameter int MAX_LINE_PIXELS = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input beats
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] mem_word,
	input  logic [7:0]  pal_index,
	input  logic [23:0] pal_color,
	// output beats
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pixel,
	output logic        word_done,
	output logic        line_end
);

	localparam int          IdxW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0]  PalEnd  = 9'(PALETTE_ENTRIES);
	localparam logic [11:0] MaxLine = 12'(MAX_LINE_PIXELS);

	// configuration registers
	logic [2:0]  depth_q;
	logic [1:0]  scale_q;
	logic [11:0] lpix_q;

	// word shift register stage
	logic [31:0] word_q;
	logic [5:0]  remain_q;
	logic        busy_q;
	logic [11:0] line_pos_q;
	logic [PALETTE_ENTRIES-1:0] pal_valid_q;

	// output stage, aligned with the palette read data
	logic        valid_s1;
	pix_kind_t   kind_s1;
	logic [31:0] raw_s1;
	logic        ok_s1;
	logic        done_s1;
	logic        lend_s1;
	logic        copy_s1;

	logic        cfg_wr;
	logic        in_fire;
	logic        pal_wr;
	logic        word_start;
	logic        out_fire;
	logic        s1_free;
	logic        load;
	logic [7:0]  idx;
	logic        idx_ok;
	logic [11:0] limit;
	logic        ends_line;
	logic        last_pix;
	logic        two_copies;
	logic [23:0] pal_rdata;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite;
	assign in_ready   = !busy_q;
	assign in_fire    = in_valid && in_ready;
	assign pal_wr     = in_fire && func && ({1'b0, pal_index} < PalEnd);
	assign word_start = in_fire && !func && (depth_q <= DEPTH_32BPP);
	assign out_valid  = valid_s1;
	assign out_fire   = valid_s1 && out_ready;
	assign s1_free    = !valid_s1 || (out_ready && !copy_s1);
	assign load       = busy_q && s1_free;
	assign two_copies = scale_q[1];

	always_comb begin
		prdata = 32'd0;
		case (paddr[3:2])
			REG_DEPTH: prdata = {29'd0, depth_q};
			REG_SCALE: prdata = {30'd0, scale_q};
			REG_LINE:  prdata = {20'd0, lpix_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 3'd0;
			scale_q <= SCALE_RESET;
			lpix_q  <= LINE_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEPTH: depth_q <= pwdata[2:0];
				REG_SCALE: scale_q <= pwdata[1:0];
				REG_LINE:  lpix_q  <= pwdata[11:0];
				default:   ;
			endcase
		end
	end

	// current pixel digit and line bookkeeping
	always_comb begin
		idx    = word_q[7:0] & idx_mask(depth_q);
		idx_ok = ({1'b0, idx} < PalEnd) && pal_valid_q[idx[IdxW-1:0]];
		if (lpix_q == 12'd0) begin
			limit = 12'd1;
		end else if (lpix_q > MaxLine) begin
			limit = MaxLine;
		end else begin
			limit = lpix_q;
		end
		ends_line = ({1'b0, line_pos_q} + 13'd1) >= {1'b0, limit};
		last_pix  = ends_line || (remain_q == 6'd1);
	end

	fbpu_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (pal_wr),
		.waddr(pal_index[IdxW-1:0]),
		.wdata(pal_color),
		.re   (load),
		.raddr(idx[IdxW-1:0]),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (pal_wr) begin
			pal_valid_q[pal_index[IdxW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			remain_q   <= 6'd0;
			line_pos_q <= 12'd0;
		end else if (word_start) begin
			busy_q   <= 1'b1;
			remain_q <= pix_count(depth_q);
		end else if (load) begin
			remain_q <= remain_q - 6'd1;
			// surplus pixels of a word that crosses the line end are dropped
			if (last_pix) begin
				busy_q <= 1'b0;
			end
			if (ends_line) begin
				line_pos_q <= 12'd0;
			end else begin
				line_pos_q <= line_pos_q + 12'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_start) begin
			word_q <= mem_word;
		end else if (load) begin
			word_q <= next_digit(word_q, depth_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			copy_s1  <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			copy_s1  <= two_copies;
		end else if (out_fire) begin
			if (copy_s1) begin
				copy_s1 <= 1'b0;
			end else begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			raw_s1  <= word_q;
			ok_s1   <= idx_ok;
			done_s1 <= last_pix;
			lend_s1 <= ends_line;
			if (depth_q == DEPTH_32BPP) begin
				kind_s1 <= KIND_WORD;
			end else if (depth_q == DEPTH_16BPP) begin
				kind_s1 <= KIND_565;
			end else begin
				kind_s1 <= KIND_PAL;
			end
		end
	end

	always_comb begin
		case (kind_s1)
			KIND_WORD: pixel = {raw_s1[7:0], raw_s1[15:8], raw_s1[23:16], raw_s1[31:24]};
			KIND_565:  pixel = {8'd0, raw_s1[4:0], 3'd0, 1'b0, raw_s1[10:5], 1'b0,
				raw_s1[15:11], 3'd0};
			default:   pixel = ok_s1 ? {8'd0, pal_rdata[7:0], pal_rdata[15:8], pal_rdata[23:16]}
				: 32'd0;
		endcase
	end

	// flags ride on the final copy only
	assign word_done = done_s1 && !copy_s1;
	assign line_end  = lend_s1 && !copy_s1;

	`ASSERT_NEXT(a_word_start_busy, word_start, busy_q, "accepted word did not start unpacking")
	`ASSERT_ALWAYS(a_line_end_done, !(out_valid && line_end) || word_done, "line end without word done")
	`ASSERT_ALWAYS(a_no_rw_clash, !(load && pal_wr), "palette read during palette write")
	`ASSERT_ALWAYS(a_copy_valid, !copy_s1 || valid_s1, "pending copy with empty output stage")
	`ASSERT_ALWAYS(a_line_pos_range, line_pos_q != 12'hfff, "line position out of range")

endmodule

// File: sv/fbpu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbpu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
